// ===== rtl/move_to_front_list_core_defines.svh =====
// ----------------------------------------------------------------------------
// move_to_front_list_core_defines.svh
// Assertion macros shared by the list core RTL. Each macro expects signals
// named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_LIST_CORE_DEFINES_SVH
`define MOVE_TO_FRONT_LIST_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define MTFL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mtfl assertion failed");

// Condition must never be true outside reset.
`define MTFL_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mtfl forbidden condition seen");

`else

`define MTFL_ASSERT(lbl, prop)
`define MTFL_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== rtl/mtfl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtfl_pkg
// Types, command codes and sizing constants for the move-to-front list core.
// ----------------------------------------------------------------------------
`default_nettype none

package mtfl_pkg;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int LEN_W   = 8;
    localparam int CMD_W   = 2;

    // Default list capacity
    localparam int CAPACITY_DEF = 128;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Command beat
    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    // Response beat
    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] read_value;
        logic [LEN_W-1:0]          list_length;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/mtfl_ram.sv =====
// ----------------------------------------------------------------------------
// mtfl_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/move_to_front_list_core.sv =====
// ----------------------------------------------------------------------------
// move_to_front_list_core
// Bounded list of signed 32-bit entries with insert, move-to-front search and
// read, held in one RAM and walked one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+---------------------------
//  cmd     | in        | cmd_valid/cmd_ready | cmd_t: command,position,value
//  rsp     | out       | rsp_valid/rsp_ready | rsp_t: ok,read_value,list_length
//
//  Read: one RAM read, then the response. Insert at position p: shift walk
//  from the tail down to p (none for an append), then one write. Search:
//  scan from the tail with one key compare per entry, then fill the front if
//  the key matched. Rejected commands and a search on an empty list finish in
//  the accept cycle. The single RAM read/write port pair paces the walks.
//  Reset clears the length and the sequencer; no clearing pass is needed.
//  cmd_ready is low while a command is being worked and while an untaken
//  response waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "move_to_front_list_core_defines.svh"

module move_to_front_list_core
    import mtfl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_RD_WAIT   = 6'b000010,
        ST_INS_SHIFT = 6'b000100,
        ST_INS_WRITE = 6'b001000,
        ST_SRCH_SCAN = 6'b010000,
        ST_SRCH_FILL = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         rd_addr_reg, rd_addr_next;
    logic [AW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]         lo_reg, lo_next;
    logic [VALUE_W-1:0]    key_reg, key_next;
    logic                  hit_reg, hit_next;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic                  accept;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_W-1:0]    wr_data;
    logic [VALUE_W-1:0]    ram_rd_data;
    logic                  key_hit;
    logic                  rsp_set;
    logic                  rsp_ok;
    logic [VALUE_W-1:0]    rsp_rdval;
    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         cnt_next_x;
    logic [AW-1:0]         pos_addr;
    logic [AW-1:0]         tail_addr;
    logic                  ins_ok;
    logic                  ins_append;
    logic                  rd_ok;

    // Entry store
    mtfl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_next),
        .rd_data (ram_rd_data)
    );

    // Key compare against the RAM read data, used by the search scan
    assign key_hit = (ram_rd_data == key_reg);

    // Bounds checks on the incoming command
    assign pos_x      = XW'(cmd.position);
    assign cnt_x      = XW'(cnt_reg);
    assign pos_addr   = AW'(cmd.position - 1'b1);
    assign tail_addr  = AW'(cnt_reg - 1'b1);
    assign ins_ok     = (cmd.position != '0) && ((pos_x - 1'b1) <= cnt_x)
                        && (cnt_x != XW'(CAPACITY));
    assign ins_append = ((pos_x - 1'b1) == cnt_x);
    assign rd_ok      = (cmd.position != '0) && (pos_x <= cnt_x);

    assign cmd_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = cmd_valid && cmd_ready;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rd_addr_next = rd_addr_reg;
        wr_ptr_next  = wr_ptr_reg;
        lo_next      = lo_reg;
        key_next     = key_reg;
        hit_next     = hit_reg;
        wr_en        = 1'b0;
        wr_addr      = wr_ptr_reg;
        wr_data      = key_reg;
        rsp_set      = 1'b0;
        rsp_ok       = 1'b0;
        rsp_rdval    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next = cmd.value;
                    case (cmd.command)
                        CMD_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                lo_next = pos_addr;
                                if (ins_append)
                                begin
                                    state_next = ST_INS_WRITE;
                                end
                                else
                                begin
                                    rd_addr_next = tail_addr;
                                    state_next   = ST_INS_SHIFT;
                                end
                            end
                            else
                            begin
                                rsp_set = 1'b1;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_set = 1'b1;
                                rsp_ok  = 1'b1;
                            end
                            else
                            begin
                                rd_addr_next = tail_addr;
                                wr_ptr_next  = tail_addr;
                                hit_next     = 1'b0;
                                state_next   = ST_SRCH_SCAN;
                            end
                        end
                        CMD_READ:
                        begin
                            if (rd_ok)
                            begin
                                rd_addr_next = pos_addr;
                                state_next   = ST_RD_WAIT;
                            end
                            else
                            begin
                                rsp_set = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_set = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                rsp_set    = 1'b1;
                rsp_ok     = 1'b1;
                rsp_rdval  = ram_rd_data;
                state_next = ST_IDLE;
            end
            // Move one entry back per cycle, tail first
            ST_INS_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = rd_addr_reg + 1'b1;
                wr_data = ram_rd_data;
                if (rd_addr_reg == lo_reg)
                begin
                    state_next = ST_INS_WRITE;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg - 1'b1;
                end
            end
            ST_INS_WRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg;
                wr_data    = key_reg;
                cnt_next   = cnt_reg + 1'b1;
                rsp_set    = 1'b1;
                rsp_ok     = 1'b1;
                state_next = ST_IDLE;
            end
            // Compact non-matching entries toward the tail
            ST_SRCH_SCAN:
            begin
                if (!key_hit)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = wr_ptr_reg;
                    wr_data     = ram_rd_data;
                    wr_ptr_next = wr_ptr_reg - 1'b1;
                end
                else
                begin
                    hit_next = 1'b1;
                end
                if (rd_addr_reg == '0)
                begin
                    if (hit_reg || key_hit)
                    begin
                        state_next = ST_SRCH_FILL;
                    end
                    else
                    begin
                        rsp_set    = 1'b1;
                        rsp_ok     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    rd_addr_next = rd_addr_reg - 1'b1;
                end
            end
            // Write the key into the front slots
            ST_SRCH_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = wr_ptr_reg;
                wr_data = key_reg;
                if (wr_ptr_reg == '0)
                begin
                    rsp_set    = 1'b1;
                    rsp_ok     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    wr_ptr_next = wr_ptr_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cnt_next_x = XW'(cnt_next);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            if (rsp_set)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        wr_ptr_reg  <= wr_ptr_next;
        lo_reg      <= lo_next;
        key_reg     <= key_next;
        if (rsp_set)
        begin
            rsp_reg.ok          <= rsp_ok;
            rsp_reg.read_value  <= rsp_rdval;
            rsp_reg.list_length <= cnt_next_x[LEN_W-1:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `MTFL_ASSERT(a_cnt_bound, cnt_reg <= CW'(CAPACITY))
    `MTFL_ASSERT(a_cnt_step, 1'b1 |=> (CW'(cnt_reg - $past(cnt_reg)) <= CW'(1)))
    `MTFL_ASSERT_NEVER(a_no_idle_write, wr_en && (state_reg == ST_IDLE))
    `MTFL_ASSERT(a_scan_order, (state_reg == ST_SRCH_SCAN) |-> (wr_ptr_reg >= rd_addr_reg))
    `MTFL_ASSERT_NEVER(a_rsp_overrun, rsp_set && rsp_valid_reg && !rsp_ready)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, move-to-front search and read commands into the list core
// through its valid/ready command channel and checks every response beat
// against a behavioral copy of the list kept in the bench. Directed commands
// cover the bounds, the empty list, duplicate hits and the unused command
// code. Random traffic then fills the list to capacity. Sender and receiver
// idle in phases, and one long receiver hold-off backs up the core.
// ----------------------------------------------------------------------------

module testbench;
    import mtfl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int RANDOM_CMDS = 750;
    localparam int PHASE_BEATS = 120;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN       = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 50;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Stimulus and expectation stores
    cmd_t pending_cmds[$];
    rsp_t expected_rsps[$];
    rsp_t want_rsp;

    // Mirror of the list contents
    logic signed [VALUE_W-1:0] mirror_list [CAPACITY];
    int mirror_len;

    // Length the list will have once all queued commands have run
    int gen_len;

    int accept_count;
    int error_count;
    int cycle_count;
    int hold_left;
    bit hold_done;

    move_to_front_list_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one command to the mirror list and return its response
    function automatic rsp_t mtf_predict(cmd_t c);
        rsp_t r;
        int p;
        int i;
        int hits;
        int others;
        logic signed [VALUE_W-1:0] rest [CAPACITY];
        r = '0;
        p = int'(c.position);
        case (c.command)
            CMD_INSERT:
            begin
                if (p >= 1 && p <= mirror_len + 1 && mirror_len < CAPACITY)
                begin
                    for (i = mirror_len; i >= p; i--)
                        mirror_list[i] = mirror_list[i-1];
                    mirror_list[p-1] = c.value;
                    mirror_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_SEARCH:
            begin
                // Matches gather at the front, the rest keep their order
                hits = 0;
                others = 0;
                for (i = 0; i < mirror_len; i++)
                begin
                    if (mirror_list[i] == c.value)
                        hits++;
                    else
                    begin
                        rest[others] = mirror_list[i];
                        others++;
                    end
                end
                for (i = 0; i < hits; i++)
                    mirror_list[i] = c.value;
                for (i = 0; i < others; i++)
                    mirror_list[hits+i] = rest[i];
                r.ok = 1'b1;
            end
            CMD_READ:
            begin
                if (p >= 1 && p <= mirror_len)
                begin
                    r.read_value = mirror_list[p-1];
                    r.ok = 1'b1;
                end
            end
            default:
                r.ok = 1'b0;
        endcase
        r.list_length = mirror_len[LEN_W-1:0];
        return r;
    endfunction

    // Idle rates per traffic phase
    function automatic int sender_idle_pct();
        case ((accept_count / PHASE_BEATS) % 4)
            1:       return 69;
            3:       return 32;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case ((accept_count / PHASE_BEATS) % 4)
            2:       return 69;
            3:       return 32;
            default: return 0;
        endcase
    endfunction

    // Values drawn mostly from a small pool so searches find hits
    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) >= 70)
            return $urandom;
        case ($urandom_range(0, 7))
            0:       return 32'sh0000_0000;
            1:       return -32'sd1;
            2:       return 32'sh8000_0000;
            3:       return 32'sh7fff_ffff;
            4:       return 32'sd1;
            5:       return 32'sd42;
            6:       return 32'sh5a5a_5a5a;
            default: return -32'sd100;
        endcase
    endfunction

    // Queue a command and track the length it leaves behind
    task automatic push_cmd(logic [CMD_W-1:0] op, int pos, logic signed [VALUE_W-1:0] v);
        cmd_t c;
        c.command  = op;
        c.position = pos[POS_W-1:0];
        c.value    = v;
        pending_cmds.push_back(c);
        if (op == CMD_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
            gen_len++;
    endtask

    task automatic add_random_cmd();
        int roll;
        int pos;
        roll = $urandom_range(0, 99);
        if (roll < 36)
        begin
            // In-bounds insert, often at the head or the tail
            case ($urandom_range(0, 3))
                0:       pos = 1;
                1:       pos = gen_len + 1;
                default: pos = $urandom_range(1, gen_len + 1);
            endcase
            push_cmd(CMD_INSERT, pos, pick_value());
        end
        else if (roll < 56)
            push_cmd(CMD_SEARCH, $urandom_range(0, 255), pick_value());
        else if (roll < 80)
        begin
            pos = (gen_len == 0) ? 1 : $urandom_range(1, gen_len);
            push_cmd(CMD_READ, pos, $urandom);
        end
        else
            push_cmd(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom);
    endtask

    // Command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else if (!cmd_valid || cmd_ready)
        begin
            if (cmd_valid)
            begin
                expected_rsps.push_back(mtf_predict(cmd));
                accept_count++;
            end
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct())
            begin
                cmd       <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, started once mid-run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accept_count >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Response ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_stall_pct());
    end

    // Response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected response beat, actual %h", $time, rsp);
            end
            else
            begin
                want_rsp = expected_rsps.pop_front();
                if (rsp.ok !== want_rsp.ok)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: ok mismatch, expected %b actual %b",
                                 $time, want_rsp.ok, rsp.ok);
                end
                if (rsp.read_value !== want_rsp.read_value)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: read_value mismatch, expected %h actual %h",
                                 $time, want_rsp.read_value, rsp.read_value);
                end
                if (rsp.list_length !== want_rsp.list_length)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: list_length mismatch, expected %0d actual %0d",
                                 $time, want_rsp.list_length, rsp.list_length);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int n;
        rst_n        = 1'b0;
        mirror_len   = 0;
        gen_len      = 0;
        accept_count = 0;
        error_count  = 0;
        cycle_count  = 0;

        // Directed: empty list, bounds, extremes, duplicates, unused code
        push_cmd(CMD_SEARCH, 0, 32'sd5);
        push_cmd(CMD_READ,   1, 32'sd0);
        push_cmd(CMD_INSERT, 0, 32'sd7);
        push_cmd(CMD_INSERT, 2, 32'sd7);
        push_cmd(CMD_INSERT, 1, 32'sh7fff_ffff);
        push_cmd(CMD_INSERT, 1, 32'sh8000_0000);
        push_cmd(CMD_INSERT, 3, 32'sd0);
        push_cmd(CMD_INSERT, 2, -32'sd1);
        push_cmd(CMD_INSERT, 6, 32'sd9);
        push_cmd(CMD_INSERT, 255, $urandom);
        push_cmd(CMD_READ,   0, 32'sd0);
        for (n = 1; n <= 5; n++)
            push_cmd(CMD_READ, n, $urandom);
        push_cmd(CMD_READ,   255, -32'sd1);
        push_cmd(CMD_SEARCH, 255, 32'sh7fff_ffff);
        push_cmd(CMD_INSERT, 1, -32'sd1);
        push_cmd(CMD_SEARCH, 128, -32'sd1);
        push_cmd(CMD_SEARCH, 1, 32'sd12345);
        push_cmd(CMD_UNUSED, 255, -32'sd1);
        push_cmd(CMD_UNUSED, 0, 32'sd0);
        push_cmd(CMD_READ,   1, 32'sd0);
        push_cmd(CMD_READ,   5, 32'sd0);

        for (n = 0; n < RANDOM_CMDS; n++)
            add_random_cmd();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every command beat is taken and answered
        @(posedge clk);
        while (pending_cmds.size() > 0 || cmd_valid)
            @(posedge clk);
        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (error_count == 0 && expected_rsps.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
